// ----- sv/led_effect_sequencer_defines.svh -----
// Assertion macros used by the LED effect sequencer checker.
`ifndef LED_EFFECT_SEQUENCER_DEFINES_SVH
`define LED_EFFECT_SEQUENCER_DEFINES_SVH

// Checked only while out of reset.
`define LEDSEQ_ASSERT_RUN(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, during reset as well.
`define LEDSEQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ledseq_pkg.sv -----
// Types and constants shared by the LED effect sequencer modules.
package ledseq_pkg;

	localparam int RGB_W       = 24;
	localparam int CMD_W       = 3;
	localparam int TIMER_W     = 16;
	localparam int TAIL_W      = 3;
	localparam int N_OUT       = 5;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = N_OUT * RGB_W;
	localparam int REG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	// Worst case repeated subtractions to reduce a tail length by the LED count.
	localparam int TAIL_MOD_STEPS = ((1 << TAIL_W) - 1) / 2;

	localparam logic [TIMER_W-1:0] RESET_PERIOD   = 16'd10;
	localparam logic [TIMER_W-1:0] MIN_PERIOD     = 16'd10;
	localparam logic [TIMER_W-1:0] DEFAULT_PERIOD = 16'd100;
	localparam logic [TAIL_W-1:0]  RESET_TAIL     = 3'd1;

	typedef logic [RGB_W-1:0] rgb_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK            = 3'd0,
		CMD_SET_EQUAL       = 3'd1,
		CMD_START_RUN       = 3'd2,
		CMD_START_BLINK     = 3'd3,
		CMD_START_RUN_BLINK = 3'd4,
		CMD_TRIGGER         = 3'd5
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RUN_PERIOD   = 3'd0,
		REG_ON_PERIOD    = 3'd1,
		REG_OFF_PERIOD   = 3'd2,
		REG_TAIL_LENGTH  = 3'd3,
		REG_BLINK_RGB    = 3'd4,
		REG_RUN_RGB      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [TIMER_W-1:0] run_period;
		logic [TIMER_W-1:0] on_period;
		logic [TIMER_W-1:0] off_period;
		logic [TAIL_W-1:0]  tail;
		rgb_t               blink_rgb;
		rgb_t               run_rgb;
	} cfg_t;

	typedef struct packed {
		logic                   valid;
		rgb_t [N_OUT-1:0]       led;
	} core_res_t;

endpackage

// ----- sv/led_effect_sequencer.sv -----
// Path from an input transaction to its result: input register, then result register.
// Throughput: one transaction per cycle; the input register is held only while a finished
// result waits in the output register and the next item would produce another one.
// Reset (arst_n low, asynchronous): both channels empty, mode equal-all, LEDs black,
// configuration registers at their reset values.
module led_effect_sequencer import ledseq_pkg::*; #(
	parameter int NUM_LEDS = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cmd[2:0], fill_rgb[26:3], zero pad
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // led0_rgb .. led4_rgb, 24 bits each
	input  logic                   cfg_we,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic             valid_s1;
	cmd_t             cmd_s1;
	rgb_t             fill_s1;
	logic             out_valid_q;
	rgb_t [N_OUT-1:0] out_q;
	logic             out_free, proc, load_defaults;
	cfg_t             cfg;
	core_res_t        res;

	ledseq_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.load_defaults (load_defaults),
		.cfg           (cfg)
	);

	ledseq_core #(.NUM_LEDS(NUM_LEDS)) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (proc),
		.cmd           (cmd_s1),
		.fill          (fill_s1),
		.cfg           (cfg),
		.load_defaults (load_defaults),
		.res           (res)
	);

	// The held item moves on unless it makes a result and the output slot is full.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign proc          = valid_s1 && (!res.valid || out_free);
	assign s_axis_tready = !valid_s1 || proc;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= cmd_t'(s_axis_tdata[CMD_W-1:0]);
			fill_s1 <= s_axis_tdata[CMD_W +: RGB_W];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res.valid) out_q <= res.led;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

// ----- sv/ledseq_cfg.sv -----
// Configuration registers, including the period defaults loaded on run-and-blink start.
module ledseq_cfg import ledseq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  load_defaults,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Host writes win; otherwise, on load_defaults, periods below MIN_PERIOD are replaced by the default.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_period <= RESET_PERIOD;
			cfg_q.on_period  <= RESET_PERIOD;
			cfg_q.off_period <= RESET_PERIOD;
			cfg_q.tail       <= RESET_TAIL;
			cfg_q.blink_rgb  <= '0;
			cfg_q.run_rgb    <= '0;
		end else begin
			priority if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_RUN_PERIOD:  cfg_q.run_period <= cfg_wdata[TIMER_W-1:0];
					REG_ON_PERIOD:   cfg_q.on_period  <= cfg_wdata[TIMER_W-1:0];
					REG_OFF_PERIOD:  cfg_q.off_period <= cfg_wdata[TIMER_W-1:0];
					REG_TAIL_LENGTH: cfg_q.tail       <= cfg_wdata[TAIL_W-1:0];
					REG_BLINK_RGB:   cfg_q.blink_rgb  <= cfg_wdata[RGB_W-1:0];
					REG_RUN_RGB:     cfg_q.run_rgb    <= cfg_wdata[RGB_W-1:0];
					default: ;
				endcase
			end else if (load_defaults) begin
				if (cfg_q.run_period < MIN_PERIOD) cfg_q.run_period <= DEFAULT_PERIOD;
				if (cfg_q.on_period < MIN_PERIOD) cfg_q.on_period <= DEFAULT_PERIOD;
				if (cfg_q.off_period < MIN_PERIOD) cfg_q.off_period <= DEFAULT_PERIOD;
			end else begin
				// Nothing to do: the registers hold their values.
			end
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/ledseq_core.sv -----
// Effect state, timers and LED color store; computes one transaction per cycle while enabled.
module ledseq_core import ledseq_pkg::*; #(
	parameter int NUM_LEDS = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  cmd_t      cmd,
	input  rgb_t      fill,
	input  cfg_t      cfg,
	output logic      load_defaults,
	output core_res_t res
);

	localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int MW = ((LW + 1) > TAIL_W) ? (LW + 1) : TAIL_W;

	typedef enum logic [1:0] {MODE_EQUAL, MODE_RUN, MODE_BLINK, MODE_RUN_BLINK} mode_t;
	typedef enum logic [1:0] {PH_OFF, PH_PRE, PH_ON, PH_POST} phase_t;

	// Tail length reduced modulo the LED count by up to TAIL_MOD_STEPS conditional subtractions.
	function automatic logic [LW-1:0] tail_mod(input logic [TAIL_W-1:0] t);
		logic [MW-1:0] v;
		v = MW'(t);
		for (int i = 0; i < TAIL_MOD_STEPS; i++) begin
			if (v >= MW'(NUM_LEDS)) v = v - MW'(NUM_LEDS);
		end
		return LW'(v);
	endfunction

	mode_t              mode_q, mode_d;
	phase_t             phase_q, phase_d;
	logic [LW-1:0]      lit_q, lit_d;
	logic [TIMER_W-1:0] step_q, step_d;
	logic [TIMER_W-1:0] blink_q, blink_d;
	rgb_t               store_q [NUM_LEDS];
	rgb_t               store_d [NUM_LEDS];
	logic               armed_q, armed_d;
	logic               blanked_q, blanked_d;

	logic [TIMER_W-1:0] step_inc, blink_inc, off_eff;
	logic [LW-1:0]      next_lit, tail_idx;
	logic [LW:0]        tail_sum;
	logic               do_fill, emit;
	rgb_t               fill_color;

	// Saturating tick counts and the off period as it stands after defaults.
	assign step_inc  = (step_q == '1) ? step_q : step_q + 1'b1;
	assign blink_inc = (blink_q == '1) ? blink_q : blink_q + 1'b1;
	assign off_eff   = (cfg.off_period < MIN_PERIOD) ? DEFAULT_PERIOD : cfg.off_period;

	// Next lit LED and the LED that the tail darkens behind it.
	assign next_lit = (lit_q == LW'(NUM_LEDS - 1)) ? '0 : lit_q + 1'b1;
	always_comb begin
		tail_sum = {1'b0, next_lit} + ((LW + 1)'(NUM_LEDS) - {1'b0, tail_mod(cfg.tail)});
		if (tail_sum >= (LW + 1)'(NUM_LEDS)) tail_sum = tail_sum - (LW + 1)'(NUM_LEDS);
		tail_idx = tail_sum[LW-1:0];
	end

	// Effect evaluation for the current transaction.
	always_comb begin
		mode_d     = mode_q;
		phase_d    = phase_q;
		lit_d      = lit_q;
		step_d     = step_q;
		blink_d    = blink_q;
		armed_d    = armed_q;
		blanked_d  = blanked_q;
		store_d    = store_q;
		do_fill    = 1'b0;
		fill_color = '0;
		emit       = 1'b0;
		unique case (cmd)
			CMD_TICK: begin
				step_d  = step_inc;
				blink_d = blink_inc;
				unique case (mode_q)
					MODE_EQUAL: ;
					MODE_RUN: begin
						if (step_inc >= cfg.run_period) begin
							step_d            = '0;
							store_d[lit_q]    = '0;
							lit_d             = next_lit;
							store_d[next_lit] = cfg.run_rgb;
							emit              = 1'b1;
						end
					end
					MODE_BLINK: begin
						if (phase_q == PH_ON) begin
							if (step_inc >= cfg.on_period) begin
								step_d  = '0;
								do_fill = 1'b1;
								phase_d = PH_OFF;
								emit    = 1'b1;
							end
						end else if (step_inc >= cfg.off_period) begin
							step_d     = '0;
							do_fill    = 1'b1;
							fill_color = cfg.blink_rgb;
							phase_d    = PH_ON;
							emit       = 1'b1;
						end
					end
					MODE_RUN_BLINK: begin
						if (cfg.run_rgb == '0 && cfg.blink_rgb == '0) begin
							// Both colors black: blank once, then stay quiet.
							if (!blanked_q) begin
								do_fill   = 1'b1;
								blanked_d = 1'b1;
								emit      = 1'b1;
							end
						end else begin
							blanked_d = 1'b0;
							if (armed_q) begin
								unique case (phase_q)
									PH_OFF: begin
										do_fill = 1'b1;
										phase_d = PH_PRE;
										blink_d = '0;
										emit    = 1'b1;
									end
									PH_PRE: begin
										if (blink_inc >= cfg.on_period) begin
											blink_d    = '0;
											do_fill    = 1'b1;
											fill_color = cfg.blink_rgb;
											phase_d    = PH_ON;
											emit       = 1'b1;
										end
									end
									PH_ON: begin
										if (blink_inc >= cfg.on_period) begin
											blink_d = '0;
											do_fill = 1'b1;
											phase_d = PH_POST;
											emit    = 1'b1;
										end
									end
									PH_POST: begin
										if (blink_inc >= cfg.on_period) begin
											blink_d = '0;
											phase_d = PH_OFF;
											armed_d = 1'b0;
										end
									end
								endcase
							end else if (cfg.run_rgb != '0 && step_inc >= cfg.run_period) begin
								// The tail write comes last so a zero tail darkens the lit LED.
								step_d            = '0;
								lit_d             = next_lit;
								store_d[next_lit] = cfg.run_rgb;
								store_d[tail_idx] = '0;
								emit              = 1'b1;
							end
						end
					end
				endcase
			end
			CMD_SET_EQUAL: begin
				do_fill    = 1'b1;
				fill_color = fill;
				mode_d     = MODE_EQUAL;
				emit       = 1'b1;
			end
			CMD_START_RUN: begin
				mode_d = MODE_RUN;
				lit_d  = '0;
				step_d = cfg.run_period;
			end
			CMD_START_BLINK: begin
				mode_d  = MODE_BLINK;
				phase_d = PH_OFF;
				step_d  = cfg.off_period;
			end
			CMD_START_RUN_BLINK: begin
				mode_d  = MODE_RUN_BLINK;
				lit_d   = '0;
				phase_d = PH_OFF;
				blink_d = off_eff;
			end
			CMD_TRIGGER: armed_d = 1'b1;
			default: ;
		endcase
		if (do_fill) begin
			for (int i = 0; i < NUM_LEDS; i++) store_d[i] = fill_color;
		end
	end

	assign load_defaults = en && (cmd == CMD_START_RUN_BLINK);

	// State advances only when the transaction is actually taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_EQUAL;
			phase_q   <= PH_OFF;
			lit_q     <= '0;
			step_q    <= '0;
			blink_q   <= '0;
			armed_q   <= 1'b0;
			blanked_q <= 1'b0;
			for (int i = 0; i < NUM_LEDS; i++) store_q[i] <= '0;
		end else if (en) begin
			mode_q    <= mode_d;
			phase_q   <= phase_d;
			lit_q     <= lit_d;
			step_q    <= step_d;
			blink_q   <= blink_d;
			armed_q   <= armed_d;
			blanked_q <= blanked_d;
			store_q   <= store_d;
		end
	end

	// Result carries the updated colors; outputs past the LED count read black.
	assign res.valid = emit;
	for (genvar g = 0; g < N_OUT; g++) begin : g_out
		if (g < NUM_LEDS) begin : g_led
			assign res.led[g] = store_d[g];
		end else begin : g_blank
			assign res.led[g] = '0;
		end
	end

endmodule

// ----- sv/ledseq_checker.sv -----
// Port-level checks for the LED effect sequencer and their binding to the top level.
`include "led_effect_sequencer_defines.svh"

module ledseq_checker import ledseq_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result keeps its colors.
	`LEDSEQ_ASSERT_RUN(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

	// Reset empties the result register at once.
	`LEDSEQ_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !m_axis_tvalid, "result valid during reset")

	// With room on the output side, the input side never stalls.
	`LEDSEQ_ASSERT_ALWAYS(a_no_false_stall, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input stalled with output free")

	// After reset the input side is open again.
	`LEDSEQ_ASSERT_RUN(a_ready_after_reset, $rose(arst_n) |-> s_axis_tready, "input not ready after reset")

endmodule

bind led_effect_sequencer ledseq_checker u_ledseq_checker (.*);
